FILE: hdl/wfl_pkg.sv
// ----------------------------------------------------------------------------
// wfl_pkg
// Shared types and constants for the word frequency and longest word block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfl_pkg;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 16;
	localparam int LEN_W   = 5;

	localparam logic [CHAR_W-1:0] UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] LOWER_Z = 8'd122;

	localparam logic KIND_FREQ = 1'b0;
	localparam logic KIND_LONG = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLOSE = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic              letter_en;
		logic [CHAR_W-1:0] letter;
		logic [LEN_W-1:0]  pos;
		logic              close_en;
		logic [LEN_W-1:0]  close_len;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/word_frequency_and_longest_word.sv
// ----------------------------------------------------------------------------
// word_frequency_and_longest_word
// Counts words of a byte stream and reports the most frequent and the
// longest word letter by letter at end of text.
// ----------------------------------------------------------------------------
// Text bytes are taken back to back; the item marked end of text then moves
// to a close state that closes the last word and a scan state in which the best
// entries ripple through the chain of entry cells, after which one result
// item leaves per cycle while the output side accepts. Input is taken only
// between reports. The table holds one cell per entry, each comparing the
// broadcast letters of the current word against its own stored word.
`default_nettype none

module word_frequency_and_longest_word #(
	parameter int MAX_WORD_LETTERS = 31,
	parameter int TABLE_ENTRIES    = 128,
	parameter int COUNT_BITS       = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [wfl_pkg::CHAR_W-1:0]   character,
	input  wire                          end_of_text,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         report_kind,
	output logic [wfl_pkg::CHAR_W-1:0]   letter,
	output logic [wfl_pkg::VALUE_W-1:0]  report_value,
	output logic                         last_of_word,
	output logic                         last_of_run,
	output logic                         table_overflow
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int UW = $clog2(TABLE_ENTRIES+1);
	localparam int SW = $clog2(TABLE_ENTRIES+2);
	localparam int LW = wfl_pkg::LEN_W;
	localparam int VW = wfl_pkg::VALUE_W;
	localparam int XW = (COUNT_BITS > VW) ? COUNT_BITS : VW;

	wfl_pkg::state_t    state_q;
	wfl_pkg::cell_cmd_t cmd;
	logic [LW-1:0]      cur_len_q;
	logic [UW-1:0]      used_q;
	logic               overflow_q;
	logic [SW-1:0]      scan_q;
	logic [LW-1:0]      pos_q;
	logic               kind_q;

	logic                          out_valid_q;
	logic                          kind_out_q;
	logic [wfl_pkg::CHAR_W-1:0]    letter_q;
	logic [VW-1:0]                 value_q;
	logic                          low_q;
	logic                          lor_q;
	logic                          ovf_q;

	logic [TABLE_ENTRIES-1:0]      hits;
	logic [wfl_pkg::CHAR_W-1:0]    rd_letters [TABLE_ENTRIES];
	logic [LW-1:0]                 lens       [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0]         bc  [TABLE_ENTRIES+1];
	logic [IW-1:0]                 bci [TABLE_ENTRIES+1];
	logic [LW-1:0]                 bl  [TABLE_ENTRIES+1];
	logic [IW-1:0]                 bli [TABLE_ENTRIES+1];

	logic               accept;
	logic               is_letter;
	logic               any_hit;
	logic               alloc;
	logic               full;
	logic               empty;
	logic [IW-1:0]      sel_idx;
	logic [LW-1:0]      sel_len;
	logic [LW-1:0]      word_len;
	logic [XW-1:0]      cnt_ext;
	logic [VW-1:0]      cnt_sat;
	logic               word_last;
	logic               emit_fire;

	assign in_ready  = state_q == wfl_pkg::ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign is_letter = ((character >= wfl_pkg::UPPER_A) && (character <= wfl_pkg::UPPER_Z)) ||
	                   ((character >= wfl_pkg::LOWER_A) && (character <= wfl_pkg::LOWER_Z));

	always_comb begin
		cmd.letter_en = accept && is_letter && (cur_len_q < LW'(MAX_WORD_LETTERS));
		cmd.letter    = character;
		cmd.pos       = cur_len_q;
		cmd.close_en  = (cur_len_q != '0) &&
		                ((accept && !is_letter) || (state_q == wfl_pkg::ST_CLOSE));
		cmd.close_len = cur_len_q;
	end

	assign any_hit = |hits;
	assign full    = used_q == UW'(TABLE_ENTRIES);
	assign alloc   = cmd.close_en && !any_hit && !full;

	assign bc[0]  = '0;
	assign bci[0] = '0;
	assign bl[0]  = '0;
	assign bli[0] = '0;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		wfl_cell #(
			.MAX_WORD_LETTERS (MAX_WORD_LETTERS),
			.TABLE_ENTRIES    (TABLE_ENTRIES),
			.COUNT_BITS       (COUNT_BITS),
			.IDX              (k)
		) u_cell (
			.clk              (clk),
			.arst_n           (arst_n),
			.cmd              (cmd),
			.alloc            (alloc),
			.used             (used_q),
			.hit              (hits[k]),
			.rd_pos           (pos_q),
			.rd_letter        (rd_letters[k]),
			.len              (lens[k]),
			.best_cnt_in      (bc[k]),
			.best_cnt_idx_in  (bci[k]),
			.best_len_in      (bl[k]),
			.best_len_idx_in  (bli[k]),
			.best_cnt_out     (bc[k+1]),
			.best_cnt_idx_out (bci[k+1]),
			.best_len_out     (bl[k+1]),
			.best_len_idx_out (bli[k+1])
		);
	end

	assign empty     = used_q == '0;
	assign sel_idx   = kind_q ? bli[TABLE_ENTRIES] : bci[TABLE_ENTRIES];
	assign sel_len   = lens[sel_idx];
	assign word_len  = empty ? LW'(1) : sel_len;
	assign word_last = (pos_q + LW'(1)) == word_len;
	assign cnt_ext   = XW'(bc[TABLE_ENTRIES]);
	assign cnt_sat   = (cnt_ext > XW'({VW{1'b1}})) ? {VW{1'b1}} : cnt_ext[VW-1:0];
	assign emit_fire = (state_q == wfl_pkg::ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfl_pkg::ST_IDLE;
			cur_len_q   <= '0;
			used_q      <= '0;
			overflow_q  <= 1'b0;
			scan_q      <= '0;
			pos_q       <= '0;
			kind_q      <= wfl_pkg::KIND_FREQ;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.letter_en) begin
				cur_len_q <= cur_len_q + LW'(1);
			end else if (cmd.close_en) begin
				cur_len_q <= '0;
			end
			if (alloc) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.close_en && !any_hit && full) begin
				overflow_q <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				wfl_pkg::ST_IDLE: begin
					if (accept && end_of_text) begin
						state_q <= wfl_pkg::ST_CLOSE;
					end
				end
				wfl_pkg::ST_CLOSE: begin
					scan_q  <= '0;
					state_q <= wfl_pkg::ST_SCAN;
				end
				wfl_pkg::ST_SCAN: begin
					scan_q <= scan_q + SW'(1);
					if (scan_q == SW'(TABLE_ENTRIES)) begin
						pos_q   <= '0;
						kind_q  <= wfl_pkg::KIND_FREQ;
						state_q <= wfl_pkg::ST_EMIT;
					end
				end
				wfl_pkg::ST_EMIT: begin
					if (emit_fire) begin
						if (!word_last) begin
							pos_q <= pos_q + LW'(1);
						end else if (kind_q == wfl_pkg::KIND_FREQ) begin
							pos_q  <= '0;
							kind_q <= wfl_pkg::KIND_LONG;
						end else begin
							used_q     <= '0;
							cur_len_q  <= '0;
							overflow_q <= 1'b0;
							state_q    <= wfl_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= wfl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			kind_out_q <= kind_q;
			letter_q   <= empty ? '0 : rd_letters[sel_idx];
			if (empty) begin
				value_q <= '0;
			end else if (kind_q == wfl_pkg::KIND_LONG) begin
				value_q <= VW'(bl[TABLE_ENTRIES]);
			end else begin
				value_q <= cnt_sat;
			end
			low_q <= word_last;
			lor_q <= word_last && (kind_q == wfl_pkg::KIND_LONG);
			ovf_q <= overflow_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign report_kind    = kind_out_q;
	assign letter         = letter_q;
	assign report_value   = value_q;
	assign last_of_word   = low_q;
	assign last_of_run    = lor_q;
	assign table_overflow = ovf_q;

endmodule

`default_nettype wire

FILE: hdl/wfl_cell.sv
// ----------------------------------------------------------------------------
// wfl_cell
// One table entry: stored word, length and count, a running match flag for
// the word being received, and one stage of the best-entry search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wfl_cell #(
	parameter int MAX_WORD_LETTERS = 31,
	parameter int TABLE_ENTRIES    = 128,
	parameter int COUNT_BITS       = 16,
	parameter int IDX              = 0
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wfl_pkg::cell_cmd_t                   cmd,
	input  wire                                  alloc,
	input  wire  [$clog2(TABLE_ENTRIES+1)-1:0]   used,
	output logic                                 hit,
	input  wire  [wfl_pkg::LEN_W-1:0]            rd_pos,
	output logic [wfl_pkg::CHAR_W-1:0]           rd_letter,
	output logic [wfl_pkg::LEN_W-1:0]            len,
	input  wire  [COUNT_BITS-1:0]                best_cnt_in,
	input  wire  [$clog2(TABLE_ENTRIES)-1:0]     best_cnt_idx_in,
	input  wire  [wfl_pkg::LEN_W-1:0]            best_len_in,
	input  wire  [$clog2(TABLE_ENTRIES)-1:0]     best_len_idx_in,
	output logic [COUNT_BITS-1:0]                best_cnt_out,
	output logic [$clog2(TABLE_ENTRIES)-1:0]     best_cnt_idx_out,
	output logic [wfl_pkg::LEN_W-1:0]            best_len_out,
	output logic [$clog2(TABLE_ENTRIES)-1:0]     best_len_idx_out
);

	localparam int PW  = (MAX_WORD_LETTERS > 1) ? $clog2(MAX_WORD_LETTERS) : 1;
	localparam int IW  = $clog2(TABLE_ENTRIES);
	localparam int UW  = $clog2(TABLE_ENTRIES+1);
	localparam logic [UW-1:0] MY_IDX = UW'(IDX);

	logic [wfl_pkg::CHAR_W-1:0] letters_q [MAX_WORD_LETTERS];
	logic [wfl_pkg::LEN_W-1:0]  len_q;
	logic [COUNT_BITS-1:0]      cnt_q;
	logic                       match_q;
	logic                       valid;
	logic                       free_slot;
	logic                       eq;

	assign valid     = MY_IDX < used;
	assign free_slot = MY_IDX == used;
	assign eq        = letters_q[cmd.pos[PW-1:0]] == cmd.letter;
	assign hit       = cmd.close_en && valid && match_q && (len_q == cmd.close_len);
	assign rd_letter = letters_q[rd_pos[PW-1:0]];
	assign len       = len_q;

	always_ff @(posedge clk) begin
		if (cmd.letter_en && free_slot) begin
			letters_q[cmd.pos[PW-1:0]] <= cmd.letter;
		end
		if (alloc && free_slot) begin
			len_q <= cmd.close_len;
			cnt_q <= COUNT_BITS'(1);
		end else if (hit && (cnt_q != {COUNT_BITS{1'b1}})) begin
			cnt_q <= cnt_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q          <= 1'b0;
			best_cnt_out     <= '0;
			best_cnt_idx_out <= '0;
			best_len_out     <= '0;
			best_len_idx_out <= '0;
		end else begin
			if (cmd.letter_en) begin
				match_q <= eq && ((cmd.pos == '0) || match_q);
			end
			if (valid && (cnt_q > best_cnt_in)) begin
				best_cnt_out     <= cnt_q;
				best_cnt_idx_out <= IW'(IDX);
			end else begin
				best_cnt_out     <= best_cnt_in;
				best_cnt_idx_out <= best_cnt_idx_in;
			end
			if (valid && (len_q > best_len_in)) begin
				best_len_out     <= len_q;
				best_len_idx_out <= IW'(IDX);
			end else begin
				best_len_out     <= best_len_in;
				best_len_idx_out <= best_len_idx_in;
			end
		end
	end

endmodule

`default_nettype wire
